>>> src/fpam_pkg.sv
// ----------------------------------------------------------------------------
// fpam_pkg: shared types and constants of the flat-plate added-mass block
// Holds register map codes, fixed-point constants, the sequencer state type
// and the constant tables of the sine and cosine series.
// ----------------------------------------------------------------------------
`default_nettype none

package fpam_pkg;

	// Configuration port geometry.
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	// Register indexes, taken from paddr[3:2].
	localparam logic [1:0] REG_CHORD     = 2'd0;
	localparam logic [1:0] REG_INV_DT    = 2'd1;
	localparam logic [1:0] REG_START_IDX = 2'd2;

	// Register reset values.
	localparam logic [31:0] CHORD_RST     = 32'h0001_0000;
	localparam logic [31:0] INV_DT_RST    = 32'h0001_0000;
	localparam logic [31:0] START_IDX_RST = 32'h0000_0000;

	// pi/8 in Q0.32, and angle constants in Q3.28.
	localparam logic [31:0]        PI8_Q32     = 32'd1686629713;
	localparam logic signed [33:0] TWO_PI_Q28  = 34'sd1686629713;
	localparam logic signed [33:0] PI_Q28      = 34'sd843314857;
	localparam logic signed [33:0] HALF_PI_Q28 = 34'sd421657428;
	localparam logic [31:0]        ONE_Q30     = 32'h4000_0000;

	// Unity for the normal-velocity rate scaling (shift by 16).
	localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

	// Series step indexes: sine steps occupy 0..5, cosine steps 6..11.
	localparam logic [3:0] SIN_LAST = 4'd5;
	localparam logic [3:0] COS_LAST = 4'd11;

	// Reciprocals floor(2^32 / d) of the series divisors.
	localparam logic [31:0] RCP_156 = 32'((64'd1 << 32) / 64'd156);
	localparam logic [31:0] RCP_110 = 32'((64'd1 << 32) / 64'd110);
	localparam logic [31:0] RCP_72  = 32'((64'd1 << 32) / 64'd72);
	localparam logic [31:0] RCP_42  = 32'((64'd1 << 32) / 64'd42);
	localparam logic [31:0] RCP_20  = 32'((64'd1 << 32) / 64'd20);
	localparam logic [31:0] RCP_6   = 32'((64'd1 << 32) / 64'd6);
	localparam logic [31:0] RCP_182 = 32'((64'd1 << 32) / 64'd182);
	localparam logic [31:0] RCP_132 = 32'((64'd1 << 32) / 64'd132);
	localparam logic [31:0] RCP_90  = 32'((64'd1 << 32) / 64'd90);
	localparam logic [31:0] RCP_56  = 32'((64'd1 << 32) / 64'd56);
	localparam logic [31:0] RCP_30  = 32'((64'd1 << 32) / 64'd30);
	localparam logic [31:0] RCP_12  = 32'((64'd1 << 32) / 64'd12);

	// Sequencer states.
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_ADOT,
		ST_NDOT,
		ST_VC2,
		ST_VN2,
		ST_CHP,
		ST_XX,
		ST_XX2,
		ST_H_MUL,
		ST_H_RCP,
		ST_H_FIX,
		ST_H_NEXT,
		ST_SIN,
		ST_SINR,
		ST_COS1,
		ST_COS2,
		ST_QB,
		ST_QL,
		ST_QH,
		ST_QS,
		ST_QC,
		ST_QD,
		ST_QF,
		ST_R1,
		ST_R2,
		ST_R3,
		ST_R4,
		ST_R5,
		ST_FIN
	} fpam_state_t;

	// Which added-mass quotient the divider is working on.
	typedef enum logic [1:0] {
		QS_CC,
		QS_CN,
		QS_TM
	} quot_sel_t;

	// Divisor of step k: 2m(2m+1), m=6-k (sine), (2m-1)2m, m=13-k (cosine).
	function automatic logic [7:0] horner_div(input logic [3:0] k);
		logic [7:0] d;
		unique case (k)
			4'd0:    d = 8'd156;
			4'd1:    d = 8'd110;
			4'd2:    d = 8'd72;
			4'd3:    d = 8'd42;
			4'd4:    d = 8'd20;
			4'd5:    d = 8'd6;
			4'd6:    d = 8'd182;
			4'd7:    d = 8'd132;
			4'd8:    d = 8'd90;
			4'd9:    d = 8'd56;
			4'd10:   d = 8'd30;
			4'd11:   d = 8'd12;
			default: d = 8'd1;
		endcase
		return d;
	endfunction

	// Matching reciprocal of each series divisor.
	function automatic logic [31:0] horner_recip(input logic [3:0] k);
		logic [31:0] r;
		unique case (k)
			4'd0:    r = RCP_156;
			4'd1:    r = RCP_110;
			4'd2:    r = RCP_72;
			4'd3:    r = RCP_42;
			4'd4:    r = RCP_20;
			4'd5:    r = RCP_6;
			4'd6:    r = RCP_182;
			4'd7:    r = RCP_132;
			4'd8:    r = RCP_90;
			4'd9:    r = RCP_56;
			4'd10:   r = RCP_30;
			4'd11:   r = RCP_12;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

>>> src/fpam_if.sv
// ----------------------------------------------------------------------------
// fpam_if: item channels of the flat-plate added-mass block
// Valid/ready channels for the blade element item and the corrected
// coefficient item.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpam_in_if;
	logic               valid;
	logic               ready;
	logic [31:0]        time_index;
	logic signed [31:0] angle_of_attack;
	logic signed [31:0] chordwise_velocity;
	logic signed [31:0] normal_velocity;
	logic signed [31:0] lift_in;
	logic signed [31:0] drag_in;
	logic signed [31:0] moment_in;

	modport source (
		output valid, time_index, angle_of_attack, chordwise_velocity,
		output normal_velocity, lift_in, drag_in, moment_in,
		input  ready
	);
	modport sink (
		input  valid, time_index, angle_of_attack, chordwise_velocity,
		input  normal_velocity, lift_in, drag_in, moment_in,
		output ready
	);
endinterface

interface fpam_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] lift_out;
	logic signed [31:0] drag_out;
	logic signed [31:0] moment_out;
	logic               zero_speed;

	modport source (
		output valid, lift_out, drag_out, moment_out, zero_speed,
		input  ready
	);
	modport sink (
		input  valid, lift_out, drag_out, moment_out, zero_speed,
		output ready
	);
endinterface

`default_nettype wire

>>> src/flat_plate_added_mass_correction_top.sv
// ----------------------------------------------------------------------------
// flat_plate_added_mass_correction_top: added-mass correction of coefficients
// Adds the flat-plate added-mass normal, chordwise and moment terms, rotated
// by the angle of attack, to one blade element's lift, drag and moment.
//
//   Channel   Kind           Carries
//   element   valid/ready    time index, angle, velocities, coefficients in
//   coeffs    valid/ready    corrected coefficients and zero-speed flag
//   APB       psel/penable   chord, inverse time step, start time index
//
// A moving item keeps the block busy until its result is loaded into the
// output register; the shift-subtract divider runs once per quotient.
// A zero-speed item skips the arithmetic. All multiplications run through one
// 32x32 multiplier whose product is registered every cycle.
// The finished item waits in the output register, so the next item is
// taken while coeffs stalls; a second finished item waits until it drains.
// Reset presets the sequencer, previous-step state and config registers.
// ----------------------------------------------------------------------------
`default_nettype none

module flat_plate_added_mass_correction_top (
	input  logic                          clk,
	input  logic                          arst_n,
	fpam_in_if.sink                       element,
	fpam_out_if.source                    coeffs,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fpam_pkg::ADDR_W-1:0]   paddr,
	input  logic [fpam_pkg::DATA_W-1:0]   pwdata,
	output logic [fpam_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);
	import fpam_pkg::*;

	// Magnitude of a 32-bit signed value.
	function automatic logic [31:0] abs32(input logic signed [31:0] v);
		return v[31] ? (~v + 32'd1) : v;
	endfunction

	// Magnitude of a 33-bit signed difference; it always fits 32 bits.
	function automatic logic [31:0] abs33(input logic signed [32:0] v);
		logic [32:0] m;
		m = v[32] ? (~v + 33'd1) : v;
		return m[31:0];
	endfunction

	// Magnitude of a 64-bit signed value.
	function automatic logic [63:0] abs64(input logic signed [63:0] v);
		return v[63] ? (~v + 64'd1) : v;
	endfunction

	// Apply a sign to a magnitude.
	function automatic logic signed [63:0] sterm(input logic neg, input logic [63:0] m);
		return neg ? signed'(~m + 64'd1) : signed'(m);
	endfunction

	// Saturate a sign and magnitude to 32 bits signed.
	function automatic logic signed [31:0] sat_mag(input logic neg, input logic [63:0] m);
		logic signed [31:0] res;
		if (neg) begin
			res = (m > 64'h8000_0000) ? 32'sh8000_0000 : signed'(~m[31:0] + 32'd1);
		end else begin
			res = (m > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : signed'(m[31:0]);
		end
		return res;
	endfunction

	// Saturate a 64-bit signed value to 32 bits.
	function automatic logic signed [31:0] clamp64(input logic signed [63:0] v);
		return sat_mag(v[63], abs64(v));
	endfunction

	// Shift right by 30, rounding the magnitude toward zero.
	function automatic logic signed [63:0] shr30(input logic signed [63:0] v);
		return sterm(v[63], abs64(v) >> 30);
	endfunction

	// Sequencer and control state.
	fpam_state_t state_q, state_d;
	quot_sel_t   qsel_q;
	logic [3:0]  kidx_q;
	logic [5:0]  div_cnt_q;
	logic        out_valid_q;

	// Configuration registers and previous-step state.
	logic [31:0]        chord_q;
	logic [31:0]        inv_dt_q;
	logic [31:0]        start_idx_q;
	logic [31:0]        prev_ti_q;
	logic [1:0]         new_cnt_q;
	logic signed [31:0] prev_ang_q;
	logic signed [31:0] prev_vn_q;

	// Item payload and working registers.
	logic signed [31:0] ang_q, vc_q, vn_q, lift_q, drag_q, mom_q;
	logic               zero_q;
	logic signed [32:0] da_q, dn_q;
	logic signed [31:0] adot_q, ndot_q;
	logic [63:0]        spd_q;
	logic [31:0]        p_q;
	logic [31:0]        x_q, x2_q, t_q, n_q, q0_q;
	logic               sneg_q, cneg_q;
	logic signed [31:0] s_q, c_q;
	logic [63:0]        b_q;
	logic [95:0]        num_q;
	logic [63:0]        rem_q, lo_q, quo_q;
	logic               ovf_q;
	logic signed [31:0] cc_q, cn_q, tm_q;
	logic signed [63:0] acc_q;
	logic signed [31:0] out_lift_q, out_drag_q, out_mom_q;
	logic               out_zero_q;

	// Shared multiplier.
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_q;

	// Handshakes.
	logic accept, cfg_we, fin_go;

	assign accept = element.valid && element.ready;
	assign cfg_we = psel && penable && pwrite;
	assign fin_go = !out_valid_q || coeffs.ready;

	assign element.ready     = (state_q == ST_IDLE);
	assign coeffs.valid      = out_valid_q;
	assign coeffs.lift_out   = out_lift_q;
	assign coeffs.drag_out   = out_drag_q;
	assign coeffs.moment_out = out_mom_q;
	assign coeffs.zero_speed = out_zero_q;
	assign pready            = 1'b1;

	// Register read-back.
	always_comb begin
		unique case (paddr[3:2])
			REG_CHORD:     prdata = chord_q;
			REG_INV_DT:    prdata = inv_dt_q;
			REG_START_IDX: prdata = start_idx_q;
			default:       prdata = '0;
		endcase
	end

	// Time-step bookkeeping for an accepted item.
	logic       new_time;
	logic [1:0] new_cnt_d;

	assign new_time  = element.time_index != prev_ti_q;
	assign new_cnt_d = (new_time && (new_cnt_q != 2'd2)) ? new_cnt_q + 2'd1 : new_cnt_q;

	// Angle reduction to [0, pi/2] with sign flags.
	logic signed [33:0] r0, r1, r2, r3, r4, r5;
	logic               red_sneg, red_cflip;

	always_comb begin
		r0 = {{2{ang_q[31]}}, ang_q};
		r1 = (r0 >= TWO_PI_Q28) ? r0 - TWO_PI_Q28 : r0;
		r2 = (r1 < 0) ? r1 + TWO_PI_Q28 : r1;
		r3 = (r2 < 0) ? r2 + TWO_PI_Q28 : r2;
		red_sneg = (r3 >= PI_Q28);
		r4 = red_sneg ? r3 - PI_Q28 : r3;
		red_cflip = (r4 > HALF_PI_Q28);
		r5 = red_cflip ? PI_Q28 - r4 : r4;
	end

	// Quotient operands and sign for the selected added-mass term.
	logic [31:0] quot_a;
	logic        quot_neg;

	always_comb begin
		quot_a = (qsel_q == QS_TM) ? PI8_Q32 : p_q;
		unique case (qsel_q)
			QS_CC:   quot_neg = adot_q[31] != vn_q[31];
			QS_CN:   quot_neg = !ndot_q[31] && (ndot_q != 32'sd0);
			QS_TM:   quot_neg = vn_q[31] != vc_q[31];
			default: quot_neg = 1'b0;
		endcase
	end

	// Series correction step: fix the reciprocal estimate by one.
	logic [31:0] h_rem, h_quo;
	logic [7:0]  h_div;

	always_comb begin
		h_div = horner_div(kidx_q);
		h_rem = n_q - mul_q[31:0];
		h_quo = q0_q + ((h_rem >= {24'd0, h_div}) ? 32'd1 : 32'd0);
	end

	// Sine and cosine finishing values.
	logic [31:0]        sin_mag, cos_half;
	logic signed [32:0] cos_val, cos_sgn;

	always_comb begin
		sin_mag  = mul_q[61:30];
		cos_half = mul_q[62:31];
		cos_val  = $signed({1'b0, ONE_Q30}) - $signed({1'b0, cos_half});
		cos_sgn  = cneg_q ? -cos_val : cos_val;
	end

	// One shift-subtract step of the divider.
	logic        div_top, div_ge;
	logic [63:0] div_sh;

	always_comb begin
		div_top = rem_q[63];
		div_sh  = {rem_q[62:0], lo_q[63]};
		div_ge  = div_top || (div_sh >= spd_q);
	end

	// Rotation sums and the moment term.
	logic signed [63:0] prod_s, lift_w, drag_w, tm_ext, cn_q4, cm_w, mom_w;
	logic signed [31:0] cm32;

	always_comb begin
		unique case (state_q)
			ST_R2:   prod_s = sterm(cn_q[31] ^ c_q[31], mul_q);
			ST_R3:   prod_s = sterm(cc_q[31] ^ s_q[31], mul_q);
			ST_R4:   prod_s = sterm(cn_q[31] ^ s_q[31], mul_q);
			ST_R5:   prod_s = sterm(cc_q[31] ^ c_q[31], mul_q);
			default: prod_s = '0;
		endcase
		lift_w = {{32{lift_q[31]}}, lift_q} + shr30(acc_q + prod_s);
		drag_w = {{32{drag_q[31]}}, drag_q} + shr30(acc_q - prod_s);
		tm_ext = {{32{tm_q[31]}}, tm_q};
		cn_q4  = sterm(cn_q[31], {32'd0, abs32(cn_q)} >> 2);
		cm_w   = 64'sd0 - cn_q4 - tm_ext;
		cm32   = clamp64(cm_w);
		mom_w  = {{32{mom_q[31]}}, mom_q} + {{32{cm32[31]}}, cm32};
	end

	// Operand selection of the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_ADOT: begin
				mul_a = abs33(da_q);
				mul_b = inv_dt_q;
			end
			ST_NDOT: begin
				mul_a = abs33(dn_q);
				mul_b = inv_dt_q;
			end
			ST_VC2: begin
				mul_a = abs32(vc_q);
				mul_b = abs32(vc_q);
			end
			ST_VN2: begin
				mul_a = abs32(vn_q);
				mul_b = abs32(vn_q);
			end
			ST_CHP: begin
				mul_a = chord_q;
				mul_b = PI8_Q32;
			end
			ST_XX: begin
				mul_a = x_q;
				mul_b = x_q;
			end
			ST_H_MUL, ST_COS1: begin
				mul_a = x2_q;
				mul_b = t_q;
			end
			ST_H_RCP: begin
				mul_a = mul_q[61:30];
				mul_b = horner_recip(kidx_q);
			end
			ST_H_FIX: begin
				mul_a = mul_q[63:32];
				mul_b = {24'd0, h_div};
			end
			ST_SIN: begin
				mul_a = x_q;
				mul_b = t_q;
			end
			ST_QB: begin
				unique case (qsel_q)
					QS_CC: begin
						mul_a = abs32(adot_q);
						mul_b = abs32(vn_q);
					end
					QS_CN: begin
						mul_a = abs32(ndot_q);
						mul_b = ONE_Q16;
					end
					default: begin
						mul_a = abs32(vn_q);
						mul_b = abs32(vc_q);
					end
				endcase
			end
			ST_QL: begin
				mul_a = quot_a;
				mul_b = mul_q[31:0];
			end
			ST_QH: begin
				mul_a = quot_a;
				mul_b = b_q[63:32];
			end
			ST_R1: begin
				mul_a = abs32(cn_q);
				mul_b = abs32(c_q);
			end
			ST_R2: begin
				mul_a = abs32(cc_q);
				mul_b = abs32(s_q);
			end
			ST_R3: begin
				mul_a = abs32(cn_q);
				mul_b = abs32(s_q);
			end
			ST_R4: begin
				mul_a = abs32(cc_q);
				mul_b = abs32(c_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Next state of the sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if ((element.chordwise_velocity == 32'sd0) &&
					    (element.normal_velocity == 32'sd0)) begin
						state_d = ST_FIN;
					end else begin
						state_d = ST_ADOT;
					end
				end
			end
			ST_ADOT:  state_d = ST_NDOT;
			ST_NDOT:  state_d = ST_VC2;
			ST_VC2:   state_d = ST_VN2;
			ST_VN2:   state_d = ST_CHP;
			ST_CHP:   state_d = ST_XX;
			ST_XX:    state_d = ST_XX2;
			ST_XX2:   state_d = ST_H_MUL;
			ST_H_MUL: state_d = ST_H_RCP;
			ST_H_RCP: state_d = ST_H_FIX;
			ST_H_FIX: state_d = ST_H_NEXT;
			ST_H_NEXT: begin
				if (kidx_q == SIN_LAST) begin
					state_d = ST_SIN;
				end else if (kidx_q == COS_LAST) begin
					state_d = ST_COS1;
				end else begin
					state_d = ST_H_MUL;
				end
			end
			ST_SIN:   state_d = ST_SINR;
			ST_SINR:  state_d = ST_H_MUL;
			ST_COS1:  state_d = ST_COS2;
			ST_COS2:  state_d = ST_QB;
			ST_QB:    state_d = ST_QL;
			ST_QL:    state_d = ST_QH;
			ST_QH:    state_d = ST_QS;
			ST_QS:    state_d = ST_QC;
			ST_QC:    state_d = ST_QD;
			ST_QD: begin
				if (div_cnt_q == 6'd63) begin
					state_d = ST_QF;
				end
			end
			ST_QF: begin
				if (qsel_q == QS_TM) begin
					state_d = ST_R1;
				end else begin
					state_d = ST_QB;
				end
			end
			ST_R1:    state_d = ST_R2;
			ST_R2:    state_d = ST_R3;
			ST_R3:    state_d = ST_R4;
			ST_R4:    state_d = ST_R5;
			ST_R5:    state_d = ST_FIN;
			ST_FIN: begin
				if (fin_go) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control counters, output valid, configuration and previous-step state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qsel_q      <= QS_CC;
			kidx_q      <= '0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			chord_q     <= CHORD_RST;
			inv_dt_q    <= INV_DT_RST;
			start_idx_q <= START_IDX_RST;
			prev_ti_q   <= START_IDX_RST;
			new_cnt_q   <= '0;
			prev_ang_q  <= '0;
			prev_vn_q   <= '0;
		end else begin
			// Series, quotient and divider step counters.
			if (state_q == ST_XX2) begin
				kidx_q <= '0;
			end else if (state_q == ST_H_NEXT) begin
				kidx_q <= kidx_q + 4'd1;
			end
			if (state_q == ST_COS2) begin
				qsel_q <= QS_CC;
			end else if (state_q == ST_QF) begin
				unique case (qsel_q)
					QS_CC:   qsel_q <= QS_CN;
					QS_CN:   qsel_q <= QS_TM;
					default: qsel_q <= QS_CC;
				endcase
			end
			if (state_q == ST_QC) begin
				div_cnt_q <= '0;
			end else if (state_q == ST_QD) begin
				div_cnt_q <= div_cnt_q + 6'd1;
			end

			// Output register valid.
			if ((state_q == ST_FIN) && fin_go) begin
				out_valid_q <= 1'b1;
			end else if (coeffs.ready) begin
				out_valid_q <= 1'b0;
			end

			// Configuration writes.
			if (cfg_we) begin
				unique case (paddr[3:2])
					REG_CHORD:  chord_q  <= pwdata;
					REG_INV_DT: inv_dt_q <= pwdata;
					REG_START_IDX: begin
						start_idx_q <= pwdata;
						prev_ti_q   <= pwdata;
					end
					default: ;
				endcase
			end

			// Previous-step state follows the two-call new-time rule.
			if (accept) begin
				new_cnt_q <= new_cnt_d;
				if (new_time && (new_cnt_d == 2'd2)) begin
					prev_ti_q  <= element.time_index;
					prev_ang_q <= element.angle_of_attack;
					prev_vn_q  <= element.normal_velocity;
				end
				if (new_cnt_d != 2'd2) begin
					prev_ang_q <= element.angle_of_attack;
				end
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					ang_q  <= element.angle_of_attack;
					vc_q   <= element.chordwise_velocity;
					vn_q   <= element.normal_velocity;
					lift_q <= element.lift_in;
					drag_q <= element.drag_in;
					mom_q  <= element.moment_in;
					zero_q <= (element.chordwise_velocity == 32'sd0) &&
					          (element.normal_velocity == 32'sd0);
					da_q   <= {element.angle_of_attack[31], element.angle_of_attack} -
					          {prev_ang_q[31], prev_ang_q};
					dn_q   <= {element.normal_velocity[31], element.normal_velocity} -
					          {prev_vn_q[31], prev_vn_q};
				end
			end
			ST_ADOT: begin
				x_q    <= {r5[29:0], 2'b00};
				sneg_q <= red_sneg;
				cneg_q <= red_sneg ^ red_cflip;
			end
			ST_NDOT:   adot_q <= sat_mag(da_q[32], {28'd0, mul_q[63:28]});
			ST_VC2:    ndot_q <= sat_mag(dn_q[32], {16'd0, mul_q[63:16]});
			ST_VN2:    spd_q  <= mul_q;
			ST_CHP:    spd_q  <= spd_q + mul_q;
			ST_XX:     p_q    <= mul_q[63:32];
			ST_XX2: begin
				x2_q <= mul_q[61:30];
				t_q  <= ONE_Q30;
			end
			ST_H_RCP:  n_q  <= mul_q[61:30];
			ST_H_FIX:  q0_q <= mul_q[63:32];
			ST_H_NEXT: t_q  <= ONE_Q30 - h_quo;
			ST_SINR: begin
				s_q <= sneg_q ? signed'(~sin_mag + 32'd1) : signed'(sin_mag);
				t_q <= ONE_Q30;
			end
			ST_COS2:   c_q   <= cos_sgn[31:0];
			ST_QL:     b_q   <= mul_q;
			ST_QH:     num_q <= {32'd0, mul_q};
			ST_QS:     num_q <= num_q + {mul_q, 32'd0};
			ST_QC: begin
				ovf_q <= ({32'd0, num_q[95:64]} >= spd_q);
				rem_q <= {32'd0, num_q[95:64]};
				lo_q  <= num_q[63:0];
				quo_q <= '0;
			end
			ST_QD: begin
				rem_q <= div_ge ? div_sh - spd_q : div_sh;
				lo_q  <= {lo_q[62:0], 1'b0};
				quo_q <= {quo_q[62:0], div_ge};
			end
			ST_QF: begin
				unique case (qsel_q)
					QS_CC:   cc_q <= sat_mag(quot_neg, ovf_q ? '1 : quo_q);
					QS_CN:   cn_q <= sat_mag(quot_neg, ovf_q ? '1 : quo_q);
					default: tm_q <= sat_mag(quot_neg, ovf_q ? '1 : (quo_q >> 16));
				endcase
			end
			ST_R2:     acc_q  <= prod_s;
			ST_R3:     lift_q <= clamp64(lift_w);
			ST_R4:     acc_q  <= prod_s;
			ST_R5: begin
				drag_q <= clamp64(drag_w);
				mom_q  <= clamp64(mom_w);
			end
			ST_FIN: begin
				if (fin_go) begin
					out_lift_q <= lift_q;
					out_drag_q <= drag_q;
					out_mom_q  <= mom_q;
					out_zero_q <= zero_q;
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

>>> src/fpam_checker.sv
// ----------------------------------------------------------------------------
// fpam_port_checks: port-level checks of the flat-plate added-mass block
// Watches the item channels of the top level and is bound to it.
// ----------------------------------------------------------------------------
`default_nettype none

module fpam_port_checks (
	input logic        clk,
	input logic        arst_n,
	input logic        elem_valid,
	input logic        elem_ready,
	input logic        coef_valid,
	input logic        coef_ready,
	input logic [31:0] lift_out,
	input logic [31:0] drag_out,
	input logic [31:0] moment_out,
	input logic        zero_speed
);

	// The block works on one item at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		elem_valid && elem_ready |=> !elem_ready)
		else $error("element ready right after an accepted item");

	// No result appears in the cycle right after an item is taken.
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		elem_valid && elem_ready |=> !$rose(coef_valid))
		else $error("result appeared one cycle after acceptance");

	// A new result is only presented once the block is back to idle.
	a_idle_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(coef_valid) |-> elem_ready)
		else $error("result presented while the block is busy");

	// A stalled result holds its payload.
	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		coef_valid && !coef_ready |=>
			coef_valid && $stable({lift_out, drag_out, moment_out, zero_speed}))
		else $error("stalled result changed");

endmodule

bind flat_plate_added_mass_correction_top fpam_port_checks u_fpam_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.elem_valid (element.valid),
	.elem_ready (element.ready),
	.coef_valid (coeffs.valid),
	.coef_ready (coeffs.ready),
	.lift_out   (coeffs.lift_out),
	.drag_out   (coeffs.drag_out),
	.moment_out (coeffs.moment_out),
	.zero_speed (coeffs.zero_speed)
);

`default_nettype wire

>>> sim/fpam_checker.sv
// ----------------------------------------------------------------------------
// fpam_checker: prediction and comparison for the added-mass correction block
// Watches the element and coeffs channels and the register port, computes
// the corrected coefficients of every accepted element item and compares
// each coeffs item with the oldest one still outstanding.
// ----------------------------------------------------------------------------
`default_nettype none

module fpam_checker
	import fpam_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	fpam_in_if                  element,
	fpam_out_if                 coeffs,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	input  logic                pready,
	output int                  fails,
	output int                  outstanding
);

	typedef struct packed {
		logic signed [31:0] lift;
		logic signed [31:0] drag;
		logic signed [31:0] moment;
		logic               zero_speed;
	} coeff_t;

	coeff_t pending_coeffs[$];

	// Register copies and previous-step state.
	logic [63:0] chord, inv_dt;
	logic [31:0] prev_tix;
	int unsigned new_time_cnt;
	longint      prev_ang, prev_vn;

	function automatic logic [63:0] magn(input longint v);
		return (v < 0) ? 64'(-v) : 64'(v);
	endfunction

	function automatic longint sat_mag(input logic neg, input logic [63:0] m);
		if (neg)
			return (m > 64'h8000_0000) ? -64'sh8000_0000 : -longint'(m);
		return (m > 64'h7FFF_FFFF) ? 64'sh7FFF_FFFF : longint'(m);
	endfunction

	function automatic longint clamp32(input longint v);
		return sat_mag(v < 0, magn(v));
	endfunction

	function automatic longint shr_tz(input longint v, input int sh);
		logic [63:0] m;
		m = magn(v) >> sh;
		return (v < 0) ? -longint'(m) : longint'(m);
	endfunction

	// Signed, saturated (a*b/d) >> sh with the quotient truncated.
	function automatic longint quotient(input logic neg, input logic [63:0] a,
			input logic [63:0] b, input logic [63:0] d, input int sh);
		logic [127:0] prod, q;
		prod = {64'd0, a} * {64'd0, b};
		if (prod[127:64] >= d)
			return sat_mag(neg, '1);
		q = prod / {64'd0, d};
		return sat_mag(neg, q[63:0] >> sh);
	endfunction

	// Series sine and cosine, Q2.30, of a Q3.28 angle.
	task automatic sine_cosine(input longint ang, output longint s, output longint c);
		longint      r, sv, cv;
		logic        sneg, cneg;
		logic [63:0] x, x2, t;
		r = ang % longint'(TWO_PI_Q28);
		sneg = 0;
		cneg = 0;
		if (r < 0)
			r += longint'(TWO_PI_Q28);
		if (r >= longint'(PI_Q28)) begin
			r -= longint'(PI_Q28);
			sneg = 1;
			cneg = 1;
		end
		if (r > longint'(HALF_PI_Q28)) begin
			r = longint'(PI_Q28) - r;
			cneg = !cneg;
		end
		x = 64'(r) << 2;
		x2 = (x * x) >> 30;
		t = 64'd1 << 30;
		for (int k = 6; k >= 1; k--)
			t = (64'd1 << 30) - ((x2 * t) >> 30) / 64'((2 * k) * (2 * k + 1));
		sv = longint'((x * t) >> 30);
		t = 64'd1 << 30;
		for (int k = 7; k >= 2; k--)
			t = (64'd1 << 30) - ((x2 * t) >> 30) / 64'((2 * k - 1) * (2 * k));
		cv = (longint'(1) << 30) - longint'(((x2 * t) >> 30) / 64'd2);
		s = sneg ? -sv : sv;
		c = cneg ? -cv : cv;
	endtask

	// Corrected coefficients of one element; advances the previous-step state.
	task automatic correct_element(input logic [31:0] tix, input longint ang,
			input longint vc, input longint vn, input longint lift,
			input longint drag, input longint mom, output coeff_t res);
		longint      da, dn, adot, ndot, cc, cn, tm, cm, s, c;
		logic [63:0] spd, p;
		da = ang - prev_ang;
		dn = vn - prev_vn;
		adot = sat_mag(da < 0, (magn(da) * inv_dt) >> 28);
		ndot = sat_mag(dn < 0, (magn(dn) * inv_dt) >> 16);
		if (tix != prev_tix) begin
			if (new_time_cnt < 2)
				new_time_cnt++;
			if (new_time_cnt > 1) begin
				prev_tix = tix;
				prev_ang = ang;
				prev_vn = vn;
			end
		end
		if (new_time_cnt <= 1)
			prev_ang = ang;
		spd = 64'(vc * vc) + 64'(vn * vn);
		res.zero_speed = (spd == 0);
		if (spd != 0) begin
			p = (chord * 64'(PI8_Q32)) >> 32;
			cc = quotient((adot < 0) != (vn < 0), p, magn(adot) * magn(vn), spd, 0);
			cn = quotient(ndot > 0, p, magn(ndot) << 16, spd, 0);
			tm = quotient((vn < 0) != (vc < 0), 64'(PI8_Q32), magn(vn) * magn(vc),
				spd, 16);
			cm = clamp32(-(cn / 4) - tm);
			sine_cosine(ang, s, c);
			lift = clamp32(lift + shr_tz(cn * c + cc * s, 30));
			drag = clamp32(drag + shr_tz(cn * s - cc * c, 30));
			mom = clamp32(mom + cm);
		end
		res.lift = 32'(lift);
		res.drag = 32'(drag);
		res.moment = 32'(mom);
	endtask

	task automatic report(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
		fails++;
	endtask

	initial fails = 0;
	assign outstanding = pending_coeffs.size();

	always @(posedge clk or negedge arst_n) begin
		coeff_t res, want;
		if (!arst_n) begin
			chord = 64'(CHORD_RST);
			inv_dt = 64'(INV_DT_RST);
			prev_tix = START_IDX_RST;
			new_time_cnt = 0;
			prev_ang = 0;
			prev_vn = 0;
			pending_coeffs.delete();
		end else begin
			// Register writes.
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_CHORD:     chord = 64'(pwdata);
					REG_INV_DT:    inv_dt = 64'(pwdata);
					REG_START_IDX: prev_tix = pwdata;
					default: ;
				endcase
			end
			// Accepted element item.
			if (element.valid && element.ready) begin
				correct_element(element.time_index, longint'(element.angle_of_attack),
					longint'(element.chordwise_velocity),
					longint'(element.normal_velocity), longint'(element.lift_in),
					longint'(element.drag_in), longint'(element.moment_in), res);
				pending_coeffs.push_back(res);
			end
			// Accepted coeffs item.
			if (coeffs.valid && coeffs.ready) begin
				if (pending_coeffs.size() == 0) begin
					report("unexpected coeffs item, lift_out", coeffs.lift_out, 32'd0);
				end else begin
					want = pending_coeffs.pop_front();
					if (coeffs.lift_out !== want.lift)
						report("lift_out", coeffs.lift_out, want.lift);
					if (coeffs.drag_out !== want.drag)
						report("drag_out", coeffs.drag_out, want.drag);
					if (coeffs.moment_out !== want.moment)
						report("moment_out", coeffs.moment_out, want.moment);
					if (coeffs.zero_speed !== want.zero_speed)
						report("zero_speed", 32'(coeffs.zero_speed), 32'(want.zero_speed));
				end
			end
		end
	end

endmodule

`default_nettype wire

>>> sim/tb_flat_plate_added_mass_correction_top.sv
// ----------------------------------------------------------------------------
// tb_flat_plate_added_mass_correction_top: testbench of the added-mass block
// Sends directed and random element items in bursts through several register
// settings, stalls the coeffs side on changing patterns with one long
// hold-off, and leaves prediction and comparison to the checker.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_flat_plate_added_mass_correction_top;
	import fpam_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int DRAIN_CYCLES = 300;

	logic              clk;
	logic              arst_n;
	logic              psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata, prdata;
	logic              pready;
	int                fails, outstanding;
	int                cycle_cnt;
	logic [31:0]       last_tix;

	fpam_in_if  element ();
	fpam_out_if coeffs ();

	flat_plate_added_mass_correction_top uut (
		.clk(clk), .arst_n(arst_n), .element(element.sink), .coeffs(coeffs.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	fpam_checker chk (
		.clk(clk), .arst_n(arst_n), .element(element), .coeffs(coeffs),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready), .fails(fails), .outstanding(outstanding)
	);

	initial clk = 0;
	always #5 clk = ~clk;

	// Run limit.
	initial cycle_cnt = 0;
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Receiver: stall pattern that changes mode, plus one long hold-off.
	initial begin
		int mode, span;
		logic held;
		coeffs.ready = 0;
		held = 0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 2);
			span = $urandom_range(32, 400);
			repeat (span) begin
				@(posedge clk);
				case (mode)
					0: coeffs.ready <= 1;
					1: coeffs.ready <= ($urandom_range(0, 1) == 1);
					default: coeffs.ready <= ($urandom_range(0, 4) == 0);
				endcase
			end
			if (!held && cycle_cnt > 4000) begin
				held = 1;
				@(posedge clk);
				coeffs.ready <= 0;
				repeat (3000) @(posedge clk);
			end
		end
	end

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	// Offer one item and hold it until accepted; then an optional gap.
	task automatic send_element(input logic [31:0] tix, input logic [31:0] ang,
			input logic [31:0] vc, input logic [31:0] vn, input logic [31:0] lf,
			input logic [31:0] dg, input logic [31:0] mo, input int gap);
		element.valid <= 1;
		element.time_index <= tix;
		element.angle_of_attack <= ang;
		element.chordwise_velocity <= vc;
		element.normal_velocity <= vn;
		element.lift_in <= lf;
		element.drag_in <= dg;
		element.moment_in <= mo;
		do @(posedge clk); while (!(element.valid && element.ready));
		if (gap > 0) begin
			element.valid <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		element.valid <= 0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_velocity();
		case ($urandom_range(0, 5))
			0:       return 32'd0;
			1:       return $urandom;
			2:       return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
			3:       return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			default: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
		endcase
	endfunction

	function automatic logic [31:0] rand_angle();
		if ($urandom_range(0, 3) == 0)
			return $urandom;
		return 32'($signed($urandom_range(0, 1 << 30)) - (1 << 29));
	endfunction

	function automatic logic [31:0] rand_coeff();
		if ($urandom_range(0, 4) == 0)
			return $urandom;
		return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
	endfunction

	// Random element items in bursts; time index mostly repeats or steps by one.
	task automatic random_burst(input int count);
		int burst, gap;
		logic [31:0] tix;
		burst = 0;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 5))
				0, 1:    tix = last_tix;
				2, 3:    tix = last_tix + 1;
				4:       tix = last_tix + $urandom_range(2, 9);
				default: tix = $urandom;
			endcase
			last_tix = tix;
			if (burst == 0) begin
				burst = $urandom_range(1, 12);
				gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
			end else begin
				gap = 0;
			end
			burst--;
			send_element(tix, rand_angle(), rand_velocity(), rand_velocity(),
				rand_coeff(), rand_coeff(), rand_coeff(), burst == 0 ? gap : 0);
		end
	endtask

	initial begin
		arst_n = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		element.valid = 0;
		element.time_index = '0;
		element.angle_of_attack = '0;
		element.chordwise_velocity = '0;
		element.normal_velocity = '0;
		element.lift_in = '0;
		element.drag_in = '0;
		element.moment_in = '0;
		last_tix = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;

		// Directed: zero speed, new-time counting, field and angle extremes.
		send_element(0, 32'h1000_0000, 0, 0, 32'h0001_0000, 32'hFFFF_0000, 32'd5, 0);
		send_element(0, 32'h0800_0000, 32'h0001_0000, 32'h0000_8000, 1, 2, 3, 2);
		send_element(1, 32'h8000_0000, 32'h0002_0000, 32'hFFFF_0000, 0, 0, 0, 0);
		send_element(1, 32'h7FFF_FFFF, 32'hFFFF_0000, 32'h0001_0000, 0, 0, 0, 0);
		send_element(2, 32'h1921_FB54, 32'h0001_0000, 32'h0003_0000, 0, 0, 0, 3);
		send_element(3, 32'hE6DE_04AC, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0);
		send_element(4, 32'h3243_F6A9, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0);
		send_element(32'hFFFF_FFFF, 0, 0, 32'h0000_0001, 0, 0, 0, 1);
		send_element(32'hFFFF_FFFF, 32'h6487_ED51, 32'h0000_0001, 0, 0, 0, 0, 0);
		send_element(5, 32'hFFFF_FFFF, 0, 32'h8000_0000, 0, 0, 0, 0);
		send_element(5, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
		last_tix = 5;

		// Random phases across register settings, extremes included.
		random_burst(180);
		wait_idle();
		reg_write(REG_CHORD, 32'hFFFF_FFFF);
		reg_write(REG_INV_DT, 32'hFFFF_FFFF);
		reg_write(REG_START_IDX, 32'd100);
		last_tix = 100;
		random_burst(120);
		wait_idle();
		reg_write(REG_CHORD, 32'd0);
		reg_write(REG_INV_DT, 32'd0);
		reg_write(REG_START_IDX, 32'hFFFF_FFFF);
		last_tix = 32'hFFFF_FFFF;
		random_burst(100);
		wait_idle();
		reg_write(REG_CHORD, $urandom_range(1 << 14, 1 << 19));
		reg_write(REG_INV_DT, $urandom_range(1 << 16, 1 << 24));
		reg_write(REG_START_IDX, 32'd0);
		last_tix = 0;
		random_burst(200);
		wait_idle();
		reg_write(REG_CHORD, $urandom);
		reg_write(REG_INV_DT, $urandom);
		reg_write(REG_START_IDX, $urandom);
		random_burst(200);

		wait_idle();
		if (fails == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire
